// ===== src/rrb_pkg.sv =====
`timescale 1ns / 1ps

package rrb_pkg;

	// Segment descriptor as held in both stores
	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] tag;
	} seg_t;

	// Command kinds; the codes match the func field on the input stream
	typedef enum logic [1:0] {
		K_PUT = 2'd0,
		K_GET = 2'd1,
		K_CLR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_STORED     = 4'd0,
		ST_WINDOW     = 4'd1,
		ST_FIFO_FULL  = 4'd2,
		ST_OVERLAP    = 4'd3,
		ST_TBL_FULL   = 4'd4,
		ST_DELIVERED  = 4'd5,
		ST_EMPTY      = 4'd6,
		ST_STALE      = 4'd7,
		ST_MERGE_FULL = 4'd8
	} status_t;

	// Classified command passed from front to back
	typedef struct packed {
		kind_t kind;
		seg_t  seg;
	} cmd_t;

	// One result word
	typedef struct packed {
		status_t     status;
		logic [15:0] tag;
		logic [31:0] seq;
		logic [15:0] len;
		logic [4:0]  ready;
		logic        last;
	} res_t;

	// Configuration register indexes
	localparam logic CFG_INITIAL_SEQ = 1'b0;
	localparam logic CFG_WINDOW      = 1'b1;

	localparam logic [23:0] WINDOW_RESET = 24'd65535;

endpackage

// ===== src/tcp_receive_reassembly_buffer.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Carries
// input     s_tvalid s_tready s_tdata s_tuser       func; seq, len, tag
// output    m_tvalid m_tready m_tdata m_tuser m_tlast status; tag, seq, len, ready_count
// config    wr_en wr_index wr_data                  initial_seq, window_bytes
//
// Get and clear go from idle straight to their result. A put that lands in
// sequence is stored, then takes each table head that now follows it in turn.
// Any other put scans the table entry by entry for its place and shifts the
// entries above the gap up by one before it is written in.
// A two-word command queue lets the input run ahead of the sequencer, and the
// output register lets the sequencer go on while a result waits.
// Reset is asynchronous; both stores come up empty, no clearing pass.

module tcp_receive_reassembly_buffer #(
	parameter int INORDER_DEPTH = 64,
	parameter int OOO_DEPTH     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // segment_seq, segment_len, segment_tag
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // tag_out, seq_out, len_out, ready_count, zero pad
	output logic [3:0]  m_tuser,   // status
	output logic        m_tlast,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data
);

	logic [31:0]   initial_seq_q;
	logic [23:0]   window_q;
	logic          q_valid;
	rrb_pkg::cmd_t q_cmd;
	logic          q_pop;
	rrb_pkg::res_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_seq_q <= 32'd0;
			window_q      <= rrb_pkg::WINDOW_RESET;
		end else if (wr_en) begin
			if (wr_index == rrb_pkg::CFG_INITIAL_SEQ) begin
				initial_seq_q <= wr_data;
			end else begin
				window_q <= wr_data[23:0];
			end
		end
	end

	rrb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	rrb_engine #(
		.INORDER_DEPTH (INORDER_DEPTH),
		.OOO_DEPTH     (OOO_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.initial_seq  (initial_seq_q),
		.window_bytes (window_q),
		.res_valid    (m_tvalid),
		.res          (res),
		.res_ready    (m_tready)
	);

	// Pack the result word
	assign m_tdata = {3'b000, res.ready, res.len, res.seq, res.tag};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

	// The sequencer only takes a word from the queue when there is one
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command queue popped while empty");

	// Delivery and empty results always close their word
	a_get_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == rrb_pkg::ST_DELIVERED || m_tuser == rrb_pkg::ST_EMPTY)
		|-> m_tlast)
		else $error("get result not marked last");

	// Merge drops are never the closing result of a put
	a_drop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == rrb_pkg::ST_STALE || m_tuser == rrb_pkg::ST_MERGE_FULL)
		|-> !m_tlast)
		else $error("merge drop marked last");

	// A ready count only appears on the closing stored result
	a_ready_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[68:64] != 5'd0)
		|-> m_tlast && (m_tuser == rrb_pkg::ST_STORED))
		else $error("ready count on a non-final result");

endmodule

// ===== src/rrb_front.sv =====
`timescale 1ns / 1ps

module rrb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	output logic              q_valid,
	output rrb_pkg::cmd_t     q_cmd,
	input  logic              q_pop
);

	rrb_pkg::cmd_t slot_q [2];
	logic          wr_sel_q;
	logic          rd_sel_q;
	logic [1:0]    cnt_q;
	logic          func_ok;
	logic          push;
	rrb_pkg::cmd_t in_cmd;

	// Classify: undefined func codes are taken and dropped
	assign func_ok = (s_tuser == rrb_pkg::K_PUT) || (s_tuser == rrb_pkg::K_GET) ||
		(s_tuser == rrb_pkg::K_CLR);
	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready && func_ok;

	always_comb begin
		in_cmd.kind    = rrb_pkg::kind_t'(s_tuser);
		in_cmd.seg.seq = s_tdata[31:0];
		in_cmd.seg.len = s_tdata[47:32];
		in_cmd.seg.tag = s_tdata[63:48];
	end

	// Two-slot queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_sel_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_sel_q <= 1'b0;
			rd_sel_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_sel_q <= ~wr_sel_q;
			end
			if (q_pop) begin
				rd_sel_q <= ~rd_sel_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = slot_q[rd_sel_q];

endmodule

// ===== src/rrb_engine.sv =====
`timescale 1ns / 1ps

module rrb_engine #(
	parameter int INORDER_DEPTH = 64,
	parameter int OOO_DEPTH     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rrb_pkg::cmd_t     q_cmd,
	output logic              q_pop,
	input  logic [31:0]       initial_seq,
	input  logic [23:0]       window_bytes,
	output logic              res_valid,
	output rrb_pkg::res_t     res,
	input  logic              res_ready
);

	localparam int FW  = (INORDER_DEPTH > 1) ? $clog2(INORDER_DEPTH) : 1;
	localparam int FCW = $clog2(INORDER_DEPTH + 1);
	localparam int TW  = (OOO_DEPTH > 1) ? $clog2(OOO_DEPTH) : 1;
	localparam int TCW = $clog2(OOO_DEPTH + 1);
	localparam logic [FCW-1:0] FIFO_FULL = FCW'(INORDER_DEPTH);
	localparam logic [FW-1:0]  FIFO_LAST = FW'(INORDER_DEPTH - 1);
	localparam logic [TCW-1:0] TBL_FULL  = TCW'(OOO_DEPTH);
	localparam logic [TCW:0]   TBL_WRAP  = (TCW + 1)'(OOO_DEPTH);

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_GETRD = 15'h0002,
		S_PWIN  = 15'h0004,
		S_MHEAD = 15'h0008,
		S_MCHK  = 15'h0010,
		S_TAIL  = 15'h0020,
		S_TCHK  = 15'h0040,
		S_HEAD  = 15'h0080,
		S_HCHK  = 15'h0100,
		S_SRD   = 15'h0200,
		S_SCHK  = 15'h0400,
		S_SHRD  = 15'h0800,
		S_SHWR  = 15'h1000,
		S_INS   = 15'h2000,
		S_DONE  = 15'h4000
	} state_t;

	function automatic logic seq_leq(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		begin
			d = b - a;
			return !d[31];
		end
	endfunction

	function automatic logic seq_gt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		begin
			d = a - b;
			return (d != 32'd0) && !d[31];
		end
	endfunction

	// Logical table slot to physical address, table kept as a ring
	function automatic logic [TW-1:0] phys(input logic [TW-1:0] h, input logic [TCW-1:0] l);
		logic [TCW:0] s;
		begin
			s = (TCW + 1)'(h) + {1'b0, l};
			if (s >= TBL_WRAP) begin
				s = s - TBL_WRAP;
			end
			return s[TW-1:0];
		end
	endfunction

	state_t             state_q;
	rrb_pkg::seg_t      cmd_q;
	logic [31:0]        end_q;
	logic [31:0]        lim_q;
	logic [31:0]        read_edge_q;
	logic [31:0]        nexp_q;
	logic [FW-1:0]      fifo_rptr_q;
	logic [FW-1:0]      fifo_wptr_q;
	logic [FCW-1:0]     fifo_cnt_q;
	logic [TW-1:0]      tbl_head_q;
	logic [TCW-1:0]     tbl_cnt_q;
	logic [4:0]         ready_q;
	rrb_pkg::status_t   done_status_q;
	logic               zero_q;
	logic [TCW-1:0]     pos_q;
	logic [TCW-1:0]     j_q;
	logic [TCW-1:0]     idx_q;
	logic [31:0]        prev_end_q;
	logic               res_valid_q;
	rrb_pkg::res_t      res_q;

	rrb_pkg::seg_t      fifo_mem [INORDER_DEPTH];
	rrb_pkg::seg_t      fifo_rdata_q;
	rrb_pkg::seg_t      tbl_mem [OOO_DEPTH];
	rrb_pkg::seg_t      tbl_rdata_q;

	logic               out_free;
	logic               fifo_full;
	logic               win_bad;
	logic               hd_due;
	logic               hd_exact;
	logic [31:0]        rd_end;
	logic               fifo_we;
	rrb_pkg::seg_t      fifo_wdata;
	logic               tbl_we;
	logic [TW-1:0]      tbl_waddr;
	rrb_pkg::seg_t      tbl_wdata;
	logic [TW-1:0]      tbl_raddr;
	logic               tbl_pop;
	logic               emit;
	rrb_pkg::res_t      emit_res;

	assign out_free  = !res_valid_q || res_ready;
	assign fifo_full = (fifo_cnt_q == FIFO_FULL);
	assign win_bad   = seq_gt(end_q, lim_q);
	assign hd_due    = seq_leq(tbl_rdata_q.seq, nexp_q);
	assign hd_exact  = (tbl_rdata_q.seq == nexp_q);
	assign rd_end    = tbl_rdata_q.seq + 32'(tbl_rdata_q.len);
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	// Memory controls and result selection per state
	always_comb begin
		fifo_we    = 1'b0;
		fifo_wdata = cmd_q;
		tbl_we     = 1'b0;
		tbl_waddr  = phys(tbl_head_q, j_q);
		tbl_wdata  = tbl_rdata_q;
		tbl_raddr  = tbl_head_q;
		tbl_pop    = 1'b0;
		emit       = 1'b0;
		emit_res.status = done_status_q;
		emit_res.tag    = zero_q ? 16'd0 : cmd_q.tag;
		emit_res.seq    = zero_q ? 32'd0 : cmd_q.seq;
		emit_res.len    = zero_q ? 16'd0 : cmd_q.len;
		emit_res.ready  = ready_q;
		emit_res.last   = 1'b1;
		case (state_q)
			S_GETRD: begin
				emit            = out_free;
				emit_res.status = rrb_pkg::ST_DELIVERED;
				emit_res.tag    = fifo_rdata_q.tag;
				emit_res.seq    = fifo_rdata_q.seq;
				emit_res.len    = fifo_rdata_q.len;
				emit_res.ready  = 5'd0;
			end
			S_PWIN: begin
				fifo_we = !win_bad && (cmd_q.seq == nexp_q) && !fifo_full;
			end
			S_MCHK: begin
				emit_res.tag   = tbl_rdata_q.tag;
				emit_res.seq   = tbl_rdata_q.seq;
				emit_res.len   = tbl_rdata_q.len;
				emit_res.ready = 5'd0;
				emit_res.last  = 1'b0;
				if (hd_due) begin
					if (!hd_exact) begin
						emit            = out_free;
						tbl_pop         = out_free;
						emit_res.status = rrb_pkg::ST_STALE;
					end else if (fifo_full) begin
						emit            = out_free;
						tbl_pop         = out_free;
						emit_res.status = rrb_pkg::ST_MERGE_FULL;
					end else begin
						fifo_we    = 1'b1;
						fifo_wdata = tbl_rdata_q;
						tbl_pop    = 1'b1;
					end
				end
			end
			S_TAIL: begin
				tbl_raddr = phys(tbl_head_q, tbl_cnt_q - 1'b1);
			end
			S_SRD: begin
				tbl_raddr = phys(tbl_head_q, idx_q);
			end
			S_SHRD: begin
				tbl_raddr = phys(tbl_head_q, j_q - 1'b1);
			end
			S_SHWR: begin
				tbl_we = 1'b1;
			end
			S_INS: begin
				tbl_we    = 1'b1;
				tbl_waddr = phys(tbl_head_q, pos_q);
				tbl_wdata = cmd_q;
			end
			S_DONE: begin
				emit = out_free;
			end
			default: begin
				tbl_raddr = tbl_head_q;
			end
		endcase
	end

	// In-order store
	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[fifo_wptr_q] <= fifo_wdata;
		end
		fifo_rdata_q <= fifo_mem[fifo_rptr_q];
	end

	// Out-of-order table
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rdata_q <= tbl_mem[tbl_raddr];
	end

	// Working registers of the current command
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd.seg;
			end_q <= q_cmd.seg.seq + 32'(q_cmd.seg.len);
			lim_q <= read_edge_q + 32'(window_bytes);
		end
		if (emit) begin
			res_q <= emit_res;
		end
		if (state_q == S_HCHK) begin
			prev_end_q <= rd_end;
		end else if (state_q == S_SCHK) begin
			prev_end_q <= rd_end;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			read_edge_q   <= 32'd0;
			nexp_q        <= 32'd0;
			fifo_rptr_q   <= '0;
			fifo_wptr_q   <= '0;
			fifo_cnt_q    <= '0;
			tbl_head_q    <= '0;
			tbl_cnt_q     <= '0;
			ready_q       <= 5'd0;
			done_status_q <= rrb_pkg::ST_STORED;
			zero_q        <= 1'b0;
			pos_q         <= '0;
			j_q           <= '0;
			idx_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (fifo_we) begin
				fifo_wptr_q <= (fifo_wptr_q == FIFO_LAST) ? '0 : fifo_wptr_q + 1'b1;
				fifo_cnt_q  <= fifo_cnt_q + 1'b1;
			end
			if (tbl_pop) begin
				tbl_head_q <= phys(tbl_head_q, TCW'(1));
				tbl_cnt_q  <= tbl_cnt_q - 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						ready_q <= 5'd0;
						zero_q  <= 1'b0;
						case (q_cmd.kind)
							rrb_pkg::K_PUT: begin
								state_q <= S_PWIN;
							end
							rrb_pkg::K_GET: begin
								if (fifo_cnt_q == '0) begin
									done_status_q <= rrb_pkg::ST_EMPTY;
									zero_q        <= 1'b1;
									state_q       <= S_DONE;
								end else begin
									state_q <= S_GETRD;
								end
							end
							default: begin
								read_edge_q   <= initial_seq;
								nexp_q        <= initial_seq;
								fifo_rptr_q   <= '0;
								fifo_wptr_q   <= '0;
								fifo_cnt_q    <= '0;
								tbl_head_q    <= '0;
								tbl_cnt_q     <= '0;
								done_status_q <= rrb_pkg::ST_STORED;
								zero_q        <= 1'b1;
								state_q       <= S_DONE;
							end
						endcase
					end
				end
				S_GETRD: begin
					if (out_free) begin
						read_edge_q <= read_edge_q + 32'(fifo_rdata_q.len);
						fifo_rptr_q <= (fifo_rptr_q == FIFO_LAST) ? '0 : fifo_rptr_q + 1'b1;
						fifo_cnt_q  <= fifo_cnt_q - 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_PWIN: begin
					if (win_bad) begin
						done_status_q <= rrb_pkg::ST_WINDOW;
						state_q       <= S_DONE;
					end else if (cmd_q.seq == nexp_q) begin
						if (fifo_full) begin
							done_status_q <= rrb_pkg::ST_FIFO_FULL;
							state_q       <= S_DONE;
						end else begin
							nexp_q        <= end_q;
							ready_q       <= 5'd1;
							done_status_q <= rrb_pkg::ST_STORED;
							state_q       <= S_MHEAD;
						end
					end else if (tbl_cnt_q == TBL_FULL) begin
						done_status_q <= rrb_pkg::ST_TBL_FULL;
						state_q       <= S_DONE;
					end else if (tbl_cnt_q == '0) begin
						pos_q   <= '0;
						j_q     <= '0;
						state_q <= S_SHRD;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_MHEAD: begin
					state_q <= (tbl_cnt_q == '0) ? S_DONE : S_MCHK;
				end
				S_MCHK: begin
					if (!hd_due) begin
						state_q <= S_DONE;
					end else if (!hd_exact) begin
						if (out_free) begin
							state_q <= S_MHEAD;
						end
					end else if (fifo_full) begin
						if (out_free) begin
							state_q <= S_DONE;
						end
					end else begin
						ready_q <= ready_q + 5'd1;
						nexp_q  <= rd_end;
						state_q <= S_MHEAD;
					end
				end
				S_TAIL: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					if (seq_leq(rd_end, cmd_q.seq)) begin
						pos_q   <= tbl_cnt_q;
						j_q     <= tbl_cnt_q;
						state_q <= S_SHRD;
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_HCHK;
				end
				S_HCHK: begin
					if (seq_leq(end_q, tbl_rdata_q.seq)) begin
						pos_q   <= '0;
						j_q     <= tbl_cnt_q;
						state_q <= S_SHRD;
					end else if (tbl_cnt_q < TCW'(2)) begin
						done_status_q <= rrb_pkg::ST_OVERLAP;
						state_q       <= S_DONE;
					end else begin
						idx_q   <= TCW'(1);
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					// gap between the previous entry and this one
					if (seq_leq(prev_end_q, cmd_q.seq) && seq_leq(end_q, tbl_rdata_q.seq)) begin
						pos_q   <= idx_q;
						j_q     <= tbl_cnt_q;
						state_q <= S_SHRD;
					end else if (idx_q + 1'b1 == tbl_cnt_q) begin
						done_status_q <= rrb_pkg::ST_OVERLAP;
						state_q       <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_SHRD: begin
					state_q <= (j_q == pos_q) ? S_INS : S_SHWR;
				end
				S_SHWR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_SHRD;
				end
				S_INS: begin
					tbl_cnt_q     <= tbl_cnt_q + 1'b1;
					done_status_q <= rrb_pkg::ST_STORED;
					state_q       <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
